[src/bgas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary grid automaton smoother package
// Shared types, codes and reset values for the grid smoother block.
// ----------------------------------------------------------------------------
package bgas_pkg;

  // Default side length of the square cell store.
  localparam int unsigned GRID_SIDE_DEF = 32;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 6;

  // Configuration reset values.
  localparam logic [5:0] WIDTH_RST  = 6'd30;
  localparam logic [5:0] HEIGHT_RST = 6'd30;
  localparam logic [3:0] PASSES_RST = 4'd3;
  localparam logic [3:0] THRESH_RST = 4'd4;
  localparam logic       BORDER_RST = 1'b1;

  // Command codes; the result kind echoes them.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_PASSES = 3'd2,
    CFG_THRESH = 3'd3,
    CFG_BORDER = 3'd4
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_RUN_LD0,
    ST_RUN_LD1,
    ST_RUN_LD2,
    ST_RUN_SCAN,
    ST_RUN_WB,
    ST_RUN_LDN,
    ST_RESP
  } st_e;

  // Request to the shared cell unit: one 3x3 window and the rule inputs.
  typedef struct packed {
    logic       border;
    logic       fill;
    logic [7:0] nbrs;
    logic [3:0] thresh;
  } cell_req_t;

endpackage

[src/bgas_row_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid row memory
// One row of cells per entry, one write and one registered read per cycle.
// Per-row valid flags make rows that were never written read as zero.
// ----------------------------------------------------------------------------
module bgas_row_mem #(
  parameter int unsigned GRID_SIDE = bgas_pkg::GRID_SIDE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [$clog2(GRID_SIDE)-1:0] waddr_i,
  input  logic [GRID_SIDE-1:0]         wdata_i,
  input  logic [$clog2(GRID_SIDE)-1:0] raddr_i,
  output logic [GRID_SIDE-1:0]         rdata_o
);
  import bgas_pkg::*;

  logic [GRID_SIDE-1:0] mem_q [GRID_SIDE];
  logic [GRID_SIDE-1:0] rd_q;
  logic [GRID_SIDE-1:0] valid_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : '0;

endmodule

[src/bgas_cell_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared cell update unit
// Counts the live neighbours of one cell and applies the smoothing rule.
// ----------------------------------------------------------------------------
module bgas_cell_unit (
  input  bgas_pkg::cell_req_t req_i,
  output logic                cell_o
);
  import bgas_pkg::*;

  logic [3:0] live_cnt;

  always_comb begin
    live_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      live_cnt = live_cnt + 4'(req_i.nbrs[i]);
    end
  end

  // Border cells take the fill value; interior cells need more live
  // neighbours than the threshold.
  assign cell_o = req_i.border ? req_i.fill : (live_cnt > req_i.thresh);

endmodule

[src/binary_grid_automaton_smoother_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary grid automaton smoother
// Square one-bit cell grid with write, read and multi-pass smoothing commands.
// ----------------------------------------------------------------------------
// The block holds a GRID_SIDE by GRID_SIDE grid of one-bit cells, stored one
// row per memory entry. Each command arrives as one input transfer (op in
// tuser, row/col/cell value in tdata) and answers with exactly one result
// transfer (kind in tuser, cell value in tdata). A write or read command goes
// through a memory read, an access state and a response state before its
// result is offered; an undefined op goes straight to the response state. A
// run command applies pass_count smoothing passes to the active region of h
// rows by w columns (both saturated to GRID_SIDE). Its pace is set by the
// single shared cell unit, which updates one cell per cycle while a three-row
// window of the old grid slides down the region; each row ends with a
// write-back state, followed by the fetch of the next row through the one
// read port. A run with no passes or an empty region goes straight to the
// response state. The grid reads as all zeros after reset through per-row
// valid flags, so no clearing pass is needed. The input side is not ready
// while a command is at work; a finished result waits in an output register
// and does not block the next command from being accepted. Configuration
// writes are always accepted and must only be issued while no command is in
// progress.
// ----------------------------------------------------------------------------
module binary_grid_automaton_smoother_unit #(
  parameter int unsigned GRID_SIDE = bgas_pkg::GRID_SIDE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bgas_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bgas_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Command stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,  // row[4:0], col[9:5], cell_req[10]
  input  logic [1:0]                          s_axis_tuser,  // op[1:0]
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // value[0]
  output logic [1:0]                          m_axis_tuser   // kind[1:0]
);
  import bgas_pkg::*;

  localparam int unsigned IDX_W = $clog2(GRID_SIDE);
  localparam int unsigned CNT_W = $clog2(GRID_SIDE + 1);
  localparam int unsigned CMP_W = (CNT_W > 6) ? CNT_W : 6;
  localparam int unsigned REQ_W = (CNT_W > 5) ? CNT_W : 5;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [5:0] cfg_width_q;
  logic [5:0] cfg_height_q;
  logic [3:0] cfg_passes_q;
  logic [3:0] cfg_thresh_q;
  logic       cfg_border_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RST;
      cfg_height_q <= HEIGHT_RST;
      cfg_passes_q <= PASSES_RST;
      cfg_thresh_q <= THRESH_RST;
      cfg_border_q <= BORDER_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  cfg_width_q  <= cfg_data_i[5:0];
        CFG_HEIGHT: cfg_height_q <= cfg_data_i[5:0];
        CFG_PASSES: cfg_passes_q <= cfg_data_i[3:0];
        CFG_THRESH: cfg_thresh_q <= cfg_data_i[3:0];
        CFG_BORDER: cfg_border_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The active region saturates at the store size.
  logic [CMP_W-1:0] side_ext;
  logic [CMP_W-1:0] width_ext;
  logic [CMP_W-1:0] height_ext;
  logic [CNT_W-1:0] w_eff;
  logic [CNT_W-1:0] h_eff;
  logic             run_empty;

  assign side_ext   = CMP_W'(GRID_SIDE);
  assign width_ext  = CMP_W'(cfg_width_q);
  assign height_ext = CMP_W'(cfg_height_q);
  assign w_eff      = (width_ext > side_ext) ? CNT_W'(GRID_SIDE) : CNT_W'(width_ext);
  assign h_eff      = (height_ext > side_ext) ? CNT_W'(GRID_SIDE) : CNT_W'(height_ext);
  assign run_empty  = (cfg_passes_q == '0) || (w_eff == '0) || (h_eff == '0);

  // --------------------------------------------------------------------------
  // Input unpacking
  // --------------------------------------------------------------------------
  op_e        in_op;
  logic [4:0] in_row;
  logic [4:0] in_col;
  logic       in_bit;
  logic       in_xfer;

  assign in_op   = op_e'(s_axis_tuser[1:0]);
  assign in_row  = s_axis_tdata[4:0];
  assign in_col  = s_axis_tdata[9:5];
  assign in_bit  = s_axis_tdata[10];
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  st_e                  state_q, state_d;
  logic [3:0]           passes_q, passes_d;
  logic [CNT_W-1:0]     row_q, row_d;
  logic [IDX_W-1:0]     col_q, col_d;
  logic [GRID_SIDE-1:0] prev_q, prev_d;
  logic [GRID_SIDE-1:0] cur_q, cur_d;
  logic [GRID_SIDE-1:0] nxt_q, nxt_d;
  logic [GRID_SIDE-1:0] newrow_q, newrow_d;
  op_e                  req_op_q, req_op_d;
  logic [4:0]           req_row_q, req_row_d;
  logic [4:0]           req_col_q, req_col_d;
  logic                 req_bit_q, req_bit_d;
  logic [1:0]           res_kind_q, res_kind_d;
  logic                 res_value_q, res_value_d;

  logic                 out_valid_q;
  logic [1:0]           out_kind_q;
  logic                 out_value_q;
  logic                 out_load;

  // Memory port.
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [GRID_SIDE-1:0] mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic [GRID_SIDE-1:0] mem_rdata;

  // Single-cell access decode.
  logic             req_inside;
  logic [IDX_W-1:0] req_row_idx;
  logic [IDX_W-1:0] req_col_idx;

  assign req_inside  = (REQ_W'(req_row_q) < REQ_W'(GRID_SIDE)) &&
                       (REQ_W'(req_col_q) < REQ_W'(GRID_SIDE));
  assign req_row_idx = IDX_W'(req_row_q);
  assign req_col_idx = IDX_W'(req_col_q);

  // Scan position decode.
  logic             last_col;
  logic             last_row;
  logic [CNT_W:0]   row_p2;
  logic [IDX_W-1:0] col_l;
  logic [IDX_W-1:0] col_r;

  assign last_col = (CNT_W'(col_q) + CNT_W'(1)) == w_eff;
  assign last_row = (row_q + CNT_W'(1)) == h_eff;
  assign row_p2   = {1'b0, row_q} + (CNT_W + 1)'(2);
  assign col_l    = col_q - IDX_W'(1);
  assign col_r    = col_q + IDX_W'(1);

  // Shared cell unit. Out-of-range window columns only occur at the border,
  // where the fill value wins.
  cell_req_t cell_req;
  logic      cell_new;

  assign cell_req.border = (row_q == '0) || (col_q == '0) || last_row || last_col;
  assign cell_req.fill   = cfg_border_q;
  assign cell_req.thresh = cfg_thresh_q;
  assign cell_req.nbrs   = {prev_q[col_l], prev_q[col_q], prev_q[col_r],
                            cur_q[col_l],                 cur_q[col_r],
                            nxt_q[col_l],  nxt_q[col_q],  nxt_q[col_r]};

  bgas_cell_unit u_cell (
    .req_i  (cell_req),
    .cell_o (cell_new)
  );

  bgas_row_mem #(
    .GRID_SIDE (GRID_SIDE)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            OP_WRITE, OP_READ: state_d = ST_ACCESS;
            OP_RUN:            state_d = run_empty ? ST_RESP : ST_RUN_LD0;
            default:           state_d = ST_RESP;
          endcase
        end
      end
      ST_ACCESS:   state_d = ST_RESP;
      ST_RUN_LD0:  state_d = ST_RUN_LD1;
      ST_RUN_LD1:  state_d = ST_RUN_LD2;
      ST_RUN_LD2:  state_d = ST_RUN_SCAN;
      ST_RUN_SCAN: begin
        if (last_col) begin
          state_d = ST_RUN_WB;
        end
      end
      ST_RUN_WB: begin
        if (!last_row) begin
          state_d = ST_RUN_LDN;
        end else if (passes_q == 4'd1) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_RUN_LD0;
        end
      end
      ST_RUN_LDN:  state_d = ST_RUN_SCAN;
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    passes_d      = passes_q;
    row_d         = row_q;
    col_d         = col_q;
    prev_d        = prev_q;
    cur_d         = cur_q;
    nxt_d         = nxt_q;
    newrow_d      = newrow_q;
    req_op_d      = req_op_q;
    req_row_d     = req_row_q;
    req_col_d     = req_col_q;
    req_bit_d     = req_bit_q;
    res_kind_d    = res_kind_q;
    res_value_d   = res_value_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = IDX_W'(row_q);
    mem_wdata     = newrow_q;
    mem_raddr     = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mem_raddr     = IDX_W'(in_row);
        if (in_xfer) begin
          req_op_d    = in_op;
          req_row_d   = in_row;
          req_col_d   = in_col;
          req_bit_d   = in_bit;
          res_kind_d  = s_axis_tuser[1:0];
          res_value_d = 1'b0;
          passes_d    = cfg_passes_q;
        end
      end
      ST_ACCESS: begin
        // Row data for the addressed cell is back from the memory.
        if (req_op_q == OP_READ) begin
          res_value_d = req_inside && mem_rdata[req_col_idx];
        end else if (req_inside) begin
          mem_we                 = 1'b1;
          mem_waddr              = req_row_idx;
          mem_wdata              = mem_rdata;
          mem_wdata[req_col_idx] = req_bit_q;
        end
      end
      ST_RUN_LD0: begin
        mem_raddr = '0;
      end
      ST_RUN_LD1: begin
        cur_d     = mem_rdata;
        mem_raddr = IDX_W'(1);
      end
      ST_RUN_LD2: begin
        nxt_d    = mem_rdata;
        row_d    = '0;
        col_d    = '0;
        newrow_d = cur_q;
      end
      ST_RUN_SCAN: begin
        newrow_d[col_q] = cell_new;
        col_d           = last_col ? '0 : col_q + IDX_W'(1);
      end
      ST_RUN_WB: begin
        // The window keeps the old rows, so the new row goes back at once.
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(row_q);
        mem_wdata = newrow_q;
        prev_d    = cur_q;
        cur_d     = nxt_q;
        newrow_d  = nxt_q;
        mem_raddr = (row_p2 < (CNT_W + 1)'(GRID_SIDE)) ? IDX_W'(row_p2) : '0;
        row_d     = row_q + CNT_W'(1);
        if (last_row) begin
          passes_d = passes_q - 4'd1;
        end
      end
      ST_RUN_LDN: begin
        nxt_d = mem_rdata;
      end
      ST_RESP: begin
        out_load = !out_valid_q || m_axis_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      passes_q    <= '0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      passes_q <= passes_d;
      row_q    <= row_d;
      col_q    <= col_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q      <= prev_d;
    cur_q       <= cur_d;
    nxt_q       <= nxt_d;
    newrow_q    <= newrow_d;
    req_op_q    <= req_op_d;
    req_row_q   <= req_row_d;
    req_col_q   <= req_col_d;
    req_bit_q   <= req_bit_d;
    res_kind_q  <= res_kind_d;
    res_value_q <= res_value_d;
    if (out_load) begin
      out_kind_q  <= res_kind_q;
      out_value_q <= res_value_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {7'b0, out_value_q};

`ifndef ASSERT_OFF
  // The scan column stays inside the active region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN_SCAN) |-> (CNT_W'(col_q) < w_eff))
    else $error("scan column beyond active width");

  // The scan row stays inside the active region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN_SCAN) |-> (row_q < h_eff))
    else $error("scan row beyond active height");

  // A run never works on a pass when the pass counter is exhausted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN_LD0) || (state_q == ST_RUN_LD1) || (state_q == ST_RUN_LD2) ||
     (state_q == ST_RUN_SCAN) || (state_q == ST_RUN_WB) || (state_q == ST_RUN_LDN))
    |-> (passes_q != '0))
    else $error("run active with no passes left");

  // An accepted command keeps the input side closed in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input accepted while a command is at work");

  // A result only appears from the response state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_RESP))
    else $error("result offered outside the response state");
`endif

endmodule
